[design/fdse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fdse_pkg;

  localparam int unsigned ValueW     = 15;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned ThouW      = 6;   // value / 1000 reaches 32
  localparam int unsigned NumPos     = 4;
  localparam int unsigned PosW       = 2;
  localparam int unsigned QueueDepth = 2;

  // v / 10 == (v * 52429) >> 19, exact for v below 43690
  localparam int unsigned Div10Mul   = 52429;
  localparam int unsigned Div10Shift = 19;
  localparam int unsigned ProdW      = 31;

  localparam logic [PosW-1:0]   PosUnits     = 2'd0;
  localparam logic [PosW-1:0]   PosTens      = 2'd1;
  localparam logic [PosW-1:0]   PosHundreds  = 2'd2;
  localparam logic [PosW-1:0]   PosThousands = 2'd3;
  localparam logic [ThouW-1:0]  MaxDigit     = 6'd9;

  typedef struct packed {
    logic [ThouW-1:0]  thousands;
    logic [DigitW-1:0] hundreds;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] units;
  } digits_t;

  function automatic logic [ValueW-1:0] div10(input logic [ValueW-1:0] v);
    logic [ProdW-1:0] prod;
    prod = ProdW'(v) * ProdW'(Div10Mul);
    return ValueW'(prod >> Div10Shift);
  endfunction

  function automatic logic [DigitW-1:0] rem10(input logic [ValueW-1:0] v,
                                              input logic [ValueW-1:0] q);
    logic [ValueW-1:0] r;
    r = v - (q << 3) - (q << 1);
    return r[DigitW-1:0];
  endfunction

  // active-low common-anode patterns
  function automatic logic [ByteW-1:0] seg_code(input logic [DigitW-1:0] d);
    logic [ByteW-1:0] s;
    unique case (d)
      4'd0:    s = 8'd192;
      4'd1:    s = 8'd249;
      4'd2:    s = 8'd164;
      4'd3:    s = 8'd176;
      4'd4:    s = 8'd153;
      4'd5:    s = 8'd146;
      4'd6:    s = 8'd130;
      4'd7:    s = 8'd248;
      4'd8:    s = 8'd128;
      4'd9:    s = 8'd144;
      default: s = 8'd255;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[design/fdse_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fdse_front import fdse_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic [ValueW-1:0] show_value_i,
  output logic                   dig_valid_o,
  input  wire logic              dig_ready_i,
  output digits_t                dig_o
);

  // three stages, one divide-by-ten each
  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  logic [11:0]       q1_q, q1_d;
  logic [8:0]        q2_q, q2_d;
  logic [ThouW-1:0]  q3_q, q3_d;
  logic [DigitW-1:0] u1_q, u2_q, u3_q, u1_d;
  logic [DigitW-1:0] t2_q, t3_q, t2_d;
  logic [DigitW-1:0] h3_q, h3_d;
  logic [ValueW-1:0] div1, div2, div3;
  logic              accept;

  assign rdy3   = !v3_q || dig_ready_i;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign full_o = !rdy1;
  assign accept = push_i && rdy1;

  assign div1 = div10(show_value_i);
  assign q1_d = div1[11:0];
  assign u1_d = rem10(show_value_i, div1);

  assign div2 = div10(ValueW'(q1_q));
  assign q2_d = div2[8:0];
  assign t2_d = rem10(ValueW'(q1_q), div2);

  assign div3 = div10(ValueW'(q2_q));
  assign q3_d = div3[ThouW-1:0];
  assign h3_d = rem10(ValueW'(q2_q), div3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= push_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q1_q <= q1_d;
      u1_q <= u1_d;
    end
    if (rdy2 && v1_q) begin
      q2_q <= q2_d;
      u2_q <= u1_q;
      t2_q <= t2_d;
    end
    if (rdy3 && v2_q) begin
      q3_q <= q3_d;
      u3_q <= u2_q;
      t3_q <= t2_q;
      h3_q <= h3_d;
    end
  end

  assign dig_valid_o     = v3_q;
  assign dig_o.thousands = q3_q;
  assign dig_o.hundreds  = h3_q;
  assign dig_o.tens      = t3_q;
  assign dig_o.units     = u3_q;

endmodule

`default_nettype wire

[design/fdse_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module fdse_queue import fdse_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_valid_i,
  output logic         wr_ready_o,
  input  wire digits_t wr_data_i,
  output logic         rd_valid_o,
  input  wire logic    rd_pop_i,
  output digits_t      rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  digits_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

[design/fdse_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module fdse_back import fdse_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [PosW-1:0]  cfg_idx_i,
  input  wire logic [ByteW-1:0] cfg_wdata_i,
  input  wire logic             dig_valid_i,
  output logic                  dig_pop_o,
  input  wire digits_t          dig_i,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output logic [ByteW-1:0]      shift_byte_o,
  output logic [PosW-1:0]       digit_position_o,
  output logic                  is_select_o,
  output logic                  last_o
);

  logic [ByteW-1:0]  sel_code_q [NumPos];
  logic              out_valid_q;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic [PosW-1:0]   pos_q;
  logic              sel_q;
  logic              last_q, last_d;
  logic [PosW-1:0]   step_pos_q, step_pos_d;
  logic              step_sel_q, step_sel_d;
  logic              load;
  logic [DigitW-1:0] cur_digit;
  logic              thou_big;

  assign thou_big = (dig_i.thousands > MaxDigit);
  assign load     = dig_valid_i && (!out_valid_q || pop_i);
  assign last_d   = step_sel_q && (step_pos_q == PosThousands);

  always_comb begin
    unique case (step_pos_q)
      PosUnits:    cur_digit = dig_i.units;
      PosTens:     cur_digit = dig_i.tens;
      PosHundreds: cur_digit = dig_i.hundreds;
      default:     cur_digit = dig_i.thousands[DigitW-1:0];
    endcase
    byte_d = step_sel_q ? sel_code_q[step_pos_q] : seg_code(cur_digit);
  end

  // walk segment/select pairs; thousands segment dropped when out of range
  always_comb begin
    step_pos_d = step_pos_q;
    step_sel_d = step_sel_q;
    if (last_d) begin
      step_pos_d = PosUnits;
      step_sel_d = 1'b0;
    end else if (!step_sel_q) begin
      step_sel_d = 1'b1;
    end else begin
      step_pos_d = step_pos_q + 1'b1;
      step_sel_d = (step_pos_d == PosThousands) && thou_big;
    end
  end

  assign dig_pop_o = load && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_pos_q  <= PosUnits;
      step_sel_q  <= 1'b0;
      for (int i = 0; i < NumPos; i++) sel_code_q[i] <= '0;
    end else begin
      if (cfg_we_i) sel_code_q[cfg_idx_i] <= cfg_wdata_i;
      if (load) begin
        out_valid_q <= 1'b1;
        step_pos_q  <= step_pos_d;
        step_sel_q  <= step_sel_d;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      pos_q  <= step_pos_q;
      sel_q  <= step_sel_q;
      last_q <= last_d;
    end
  end

  assign empty_o          = !out_valid_q;
  assign shift_byte_o     = byte_q;
  assign digit_position_o = pos_q;
  assign is_select_o      = sel_q;
  assign last_o           = last_q;

  a_last_is_thou_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> sel_q && (pos_q == PosThousands))
    else $error("last flag on an item other than the thousands select");

  a_mid_value_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_pos_q != PosUnits) || step_sel_q |-> dig_valid_i)
    else $error("sequencer mid-value with no digits at queue head");

  a_no_big_thou_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_valid_i && (step_pos_q == PosThousands) && !step_sel_q |-> !thou_big)
    else $error("segment step reached for thousands digit above nine");

  a_pop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_pop_o |=> (step_pos_q == PosUnits) && !step_sel_q && last_q)
    else $error("digit entry released without wrapping the sequencer");

endmodule

`default_nettype wire

[design/four_digit_segment_display_encoder.sv]
// Four-digit seven-segment encoder. Each pushed show_value is split into
// decimal digits by a three-stage divide-by-ten pipeline, queued, and then
// expanded by a sequencer into one result item per clock while pop keeps
// up: for units, tens, hundreds and thousands in turn, the active-low
// segment byte followed by that position's select byte from the select code
// registers. A thousands digit above nine yields only its select byte, so a
// value gives seven or eight items and the sequencer sets the sustained
// rate; last_o marks the thousands select byte. The user must write select
// codes via cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle; unchecked.
`timescale 1ns / 1ps
`default_nettype none

module four_digit_segment_display_encoder import fdse_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [PosW-1:0]   cfg_idx_i,
  input  wire logic [ByteW-1:0]  cfg_wdata_i,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [ValueW-1:0] show_value_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [ByteW-1:0]       shift_byte_o,
  output logic [PosW-1:0]        digit_position_o,
  output logic                   is_select_o,
  output logic                   last_o
);

  logic    f_valid, f_ready;
  digits_t f_dig;
  logic    q_valid, q_pop;
  digits_t q_dig;

  fdse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .show_value_i (show_value_i),
    .dig_valid_o  (f_valid),
    .dig_ready_i  (f_ready),
    .dig_o        (f_dig)
  );

  fdse_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_dig),
    .rd_valid_o (q_valid),
    .rd_pop_i   (q_pop),
    .rd_data_o  (q_dig)
  );

  fdse_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .dig_valid_i      (q_valid),
    .dig_pop_o        (q_pop),
    .dig_i            (q_dig),
    .empty_o          (empty),
    .pop_i            (pop),
    .shift_byte_o     (shift_byte_o),
    .digit_position_o (digit_position_o),
    .is_select_o      (is_select_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
